@@ rtl/yrp_pkg.sv @@
// Shared widths, register codes, reset values and stage types for the yaw-rate PID servo.
package yrp_pkg;

  localparam int HEADING_W  = 13;
  localparam int THROTTLE_W = 12;
  localparam int TIME_W     = 32;
  localparam int SERVO_W    = 12;
  localparam int CFG_W      = 18;
  localparam int CFG_IDX_W  = 3;

  localparam int FOLD_W     = 15;
  localparam int CHANGE_W   = 14;
  localparam int DCHANGE_W  = 15;
  localparam int P_W        = 33;
  localparam int IPROD_W    = 31;
  localparam int D_W        = 34;
  localparam int INTEG_W    = 32;
  localparam int SUM_W      = 36;
  localparam int SUMC_W     = 28;
  localparam int ROUND_W    = 29;
  localparam int CORR_W     = 13;
  localparam int SERVO_EXT_W = 14;

  localparam logic [FOLD_W-1:0]  FULL_TURN  = 15'd5760;
  localparam logic [SERVO_W-1:0] SERVO_MAX  = 12'd4095;
  localparam logic signed [ROUND_W-1:0] ROUND_HALF = 29'sd32768;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN  = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 3'd0,
    REG_PROP   = 3'd1,
    REG_INTEG  = 3'd2,
    REG_DERIV  = 3'd3,
    REG_WINDOW = 3'd4,
    REG_LIMIT  = 3'd5,
    REG_WRAP   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]  period_ms;
    logic [17:0] prop_gain;
    logic [15:0] integ_gain;
    logic [17:0] deriv_gain;
    logic [9:0]  integ_window;
    logic [10:0] output_limit;
    logic [11:0] wrap_threshold;
  } yrp_cfg_t;

  localparam yrp_cfg_t CFG_RESET = '{
    period_ms:      10'd40,
    prop_gain:      18'd22938,
    integ_gain:     16'd33,
    deriv_gain:     18'd3277,
    integ_window:   10'd16,
    output_limit:   11'd80,
    wrap_threshold: 12'd960
  };

  typedef struct packed {
    logic                  valid;
    logic                  upd;
    logic [THROTTLE_W-1:0] throttle;
  } yrp_ctl_t;

endpackage

@@ rtl/yrp_if.sv @@
// Valid/ready channel interfaces for heading samples and servo results.
interface yrp_in_if import yrp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [HEADING_W-1:0]  heading;
  logic [THROTTLE_W-1:0] base_throttle;
  logic [TIME_W-1:0]     now_ms;

  modport source (output valid, heading, base_throttle, now_ms, input ready);
  modport sink   (input valid, heading, base_throttle, now_ms, output ready);
endinterface

interface yrp_out_if import yrp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SERVO_W-1:0] servo_out;
  logic               updated;

  modport source (output valid, servo_out, updated, input ready);
  modport sink   (input valid, servo_out, updated, output ready);
endinterface

@@ rtl/yaw_rate_pid_servo.sv @@
// Top level of the yaw-rate PID servo: configuration registers and pipeline.
//
//   channel   dir  handshake      payload
//   sample    in   valid/ready    heading, base_throttle, now_ms
//   result    out  valid/ready    servo_out, updated
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// One item per cycle while no stall is held; a result passes through the six
// register ranks from input register to result register.
// Synchronous reset clears valid bits, history, accumulator; loads CFG_RESET.
// A waiting result with ready low holds every stage and drops sample.ready.
module yaw_rate_pid_servo import yrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  yrp_in_if.sink               sample,
  yrp_out_if.source            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  yrp_cfg_t cfg;
  logic     en;

  yrp_ctl_t                  ctl2, ctl4;
  logic [CHANGE_W-1:0]       change, prev_change;
  logic signed [P_W-1:0]     p_term;
  logic signed [D_W-1:0]     d_term;
  logic signed [INTEG_W-1:0] i_term;

  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_PERIOD: cfg.period_ms      <= cfg_data[9:0];
        REG_PROP:   cfg.prop_gain      <= cfg_data[17:0];
        REG_INTEG:  cfg.integ_gain     <= cfg_data[15:0];
        REG_DERIV:  cfg.deriv_gain     <= cfg_data[17:0];
        REG_WINDOW: cfg.integ_window   <= cfg_data[9:0];
        REG_LIMIT:  cfg.output_limit   <= cfg_data[10:0];
        REG_WRAP:   cfg.wrap_threshold <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  yrp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .cfg           (cfg),
    .take          (sample.valid),
    .heading       (sample.heading),
    .base_throttle (sample.base_throttle),
    .now_ms        (sample.now_ms),
    .ctl           (ctl2),
    .change        (change),
    .prev_change   (prev_change)
  );

  yrp_gain u_gain (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .ctl_in      (ctl2),
    .change      (change),
    .prev_change (prev_change),
    .ctl_out     (ctl4),
    .p_term      (p_term),
    .d_term      (d_term),
    .i_term      (i_term)
  );

  yrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .ctl_in    (ctl4),
    .p_term    (p_term),
    .d_term    (d_term),
    .i_term    (i_term),
    .out_valid (result.valid),
    .servo_out (result.servo_out),
    .updated   (result.updated)
  );

endmodule

@@ rtl/yrp_front.sv @@
// Input register, heading change with wrap folding, update timer and history state.
module yrp_front import yrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  yrp_cfg_t              cfg,
  input  logic                  take,
  input  logic [HEADING_W-1:0]  heading,
  input  logic [THROTTLE_W-1:0] base_throttle,
  input  logic [TIME_W-1:0]     now_ms,
  output yrp_ctl_t              ctl,
  output logic [CHANGE_W-1:0]   change,
  output logic [CHANGE_W-1:0]   prev_change
);

  logic                  s1_valid;
  logic [HEADING_W-1:0]  s1_heading;
  logic [THROTTLE_W-1:0] s1_throttle;
  logic [TIME_W-1:0]     s1_now;

  logic [HEADING_W-1:0]  last_heading;
  logic [CHANGE_W-1:0]   last_change;
  logic [TIME_W-1:0]     last_update_ms;

  logic signed [FOLD_W-1:0] diff, fold1, fold2, thr_s;
  logic [CHANGE_W-1:0]      change_c;
  logic [TIME_W-1:0]        elapsed;
  logic                     upd_c;

  always_comb begin
    thr_s    = $signed({3'b000, cfg.wrap_threshold});
    diff     = $signed({2'b00, s1_heading}) - $signed({2'b00, last_heading});
    fold1    = (diff < -thr_s) ? diff + $signed(FULL_TURN) : diff;
    fold2    = (fold1 > thr_s) ? fold1 - $signed(FULL_TURN) : fold1;
    change_c = fold2[CHANGE_W-1:0];
    elapsed  = s1_now - last_update_ms;
    upd_c    = elapsed > {{(TIME_W-10){1'b0}}, cfg.period_ms};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      ctl.valid      <= 1'b0;
      ctl.upd        <= 1'b0;
      last_heading   <= '0;
      last_change    <= '0;
      last_update_ms <= '0;
    end else if (en) begin
      s1_valid  <= take;
      ctl.valid <= s1_valid;
      ctl.upd   <= upd_c;
      if (s1_valid) begin
        last_heading <= s1_heading;
        last_change  <= change_c;
        if (upd_c) begin
          last_update_ms <= s1_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_heading   <= heading;
      s1_throttle  <= base_throttle;
      s1_now       <= now_ms;
      ctl.throttle <= s1_throttle;
      change       <= change_c;
      prev_change  <= last_change;
    end
  end

endmodule

@@ rtl/yrp_gain.sv @@
// Gain products and the conditionally integrating accumulator.
module yrp_gain import yrp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  yrp_cfg_t                   cfg,
  input  yrp_ctl_t                   ctl_in,
  input  logic [CHANGE_W-1:0]        change,
  input  logic [CHANGE_W-1:0]        prev_change,
  output yrp_ctl_t                   ctl_out,
  output logic signed [P_W-1:0]      p_term,
  output logic signed [D_W-1:0]      d_term,
  output logic signed [INTEG_W-1:0]  i_term
);

  yrp_ctl_t                   s3_ctl;
  logic signed [P_W-1:0]      s3_p;
  logic signed [IPROD_W-1:0]  s3_ip;
  logic signed [DCHANGE_W-1:0] s3_dchange;
  logic                       s3_inwin;
  logic signed [INTEG_W-1:0]  integral_acc;

  logic signed [CHANGE_W-1:0]  ch_s;
  logic signed [DCHANGE_W-1:0] ch_w, win_s, dchange_c;
  logic signed [P_W-1:0]       p_c;
  logic signed [IPROD_W-1:0]   ip_c;
  logic                        inwin_c;
  logic signed [D_W-1:0]       d_c;
  logic signed [INTEG_W:0]     isum;
  logic signed [INTEG_W-1:0]   isat;
  logic                        integ_en;

  always_comb begin
    ch_s      = $signed(change);
    ch_w      = DCHANGE_W'(ch_s);
    win_s     = $signed({5'b00000, cfg.integ_window});
    dchange_c = ch_w - DCHANGE_W'($signed(prev_change));
    inwin_c   = (ch_w > -win_s) && (ch_w < win_s);
    p_c       = P_W'($signed({1'b0, cfg.prop_gain})) * P_W'(ch_s);
    ip_c      = IPROD_W'($signed({1'b0, cfg.integ_gain})) * IPROD_W'(ch_s);
  end

  always_comb begin
    d_c  = D_W'($signed({1'b0, cfg.deriv_gain})) * D_W'(s3_dchange);
    isum = (INTEG_W+1)'(integral_acc) + (INTEG_W+1)'(s3_ip);
    if (isum > (INTEG_W+1)'(INTEG_MAX)) begin
      isat = INTEG_MAX;
    end else if (isum < (INTEG_W+1)'(INTEG_MIN)) begin
      isat = INTEG_MIN;
    end else begin
      isat = isum[INTEG_W-1:0];
    end
    integ_en = s3_ctl.upd && s3_inwin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl.valid  <= 1'b0;
      s3_ctl.upd    <= 1'b0;
      ctl_out.valid <= 1'b0;
      ctl_out.upd   <= 1'b0;
      integral_acc  <= '0;
    end else if (en) begin
      s3_ctl.valid  <= ctl_in.valid;
      s3_ctl.upd    <= ctl_in.upd;
      ctl_out.valid <= s3_ctl.valid;
      ctl_out.upd   <= s3_ctl.upd;
      if (s3_ctl.valid && integ_en) begin
        integral_acc <= isat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctl.throttle  <= ctl_in.throttle;
      s3_p             <= p_c;
      s3_ip            <= ip_c;
      s3_dchange       <= dchange_c;
      s3_inwin         <= inwin_c;
      ctl_out.throttle <= s3_ctl.throttle;
      p_term           <= s3_p;
      d_term           <= d_c;
      i_term           <= integ_en ? isat : integral_acc;
    end
  end

endmodule

@@ rtl/yrp_back.sv @@
// Correction sum and clamp, rounding, servo saturation, held value and result register.
module yrp_back import yrp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  yrp_cfg_t                   cfg,
  input  yrp_ctl_t                   ctl_in,
  input  logic signed [P_W-1:0]      p_term,
  input  logic signed [D_W-1:0]      d_term,
  input  logic signed [INTEG_W-1:0]  i_term,
  output logic                       out_valid,
  output logic [SERVO_W-1:0]         servo_out,
  output logic                       updated
);

  yrp_ctl_t                  s5_ctl;
  logic signed [SUMC_W-1:0]  s5_sumc;
  logic [SERVO_W-1:0]        held_servo;

  logic signed [SUM_W-1:0]       sum, lim;
  logic signed [SUMC_W-1:0]      sumc_c;
  logic signed [ROUND_W-1:0]     rounded;
  logic signed [CORR_W-1:0]      corr;
  logic signed [SERVO_EXT_W-1:0] servo_raw;
  logic [SERVO_W-1:0]            servo_sat;

  always_comb begin
    sum = SUM_W'(p_term) + SUM_W'(d_term) + SUM_W'(i_term);
    lim = $signed({9'd0, cfg.output_limit, 16'd0});
    if (sum > lim) begin
      sumc_c = lim[SUMC_W-1:0];
    end else if (sum < -lim) begin
      sumc_c = SUMC_W'(-lim);
    end else begin
      sumc_c = sum[SUMC_W-1:0];
    end
  end

  always_comb begin
    rounded   = ROUND_W'(s5_sumc) + ROUND_HALF;
    corr      = rounded[ROUND_W-1:16];
    servo_raw = $signed({2'b00, s5_ctl.throttle}) + SERVO_EXT_W'(corr);
    if (servo_raw < 0) begin
      servo_sat = '0;
    end else if (servo_raw > $signed({2'b00, SERVO_MAX})) begin
      servo_sat = SERVO_MAX;
    end else begin
      servo_sat = servo_raw[SERVO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctl.valid <= 1'b0;
      s5_ctl.upd   <= 1'b0;
      out_valid    <= 1'b0;
      held_servo   <= '0;
    end else if (en) begin
      s5_ctl.valid <= ctl_in.valid;
      s5_ctl.upd   <= ctl_in.upd;
      out_valid    <= s5_ctl.valid;
      if (s5_ctl.valid && s5_ctl.upd) begin
        held_servo <= servo_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ctl.throttle <= ctl_in.throttle;
      s5_sumc         <= sumc_c;
      servo_out       <= s5_ctl.upd ? servo_sat : held_servo;
      updated         <= s5_ctl.upd;
    end
  end

endmodule

@@ rtl/yrp_checker.sv @@
// Port-level assertions for the yaw-rate PID servo, bound to the top level.
module yrp_checker import yrp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SERVO_W-1:0] servo_out,
  input logic               updated
);

  logic [SERVO_W-1:0] last_servo;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_servo <= '0;
    end else if (out_valid && out_ready) begin
      last_servo <= servo_out;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result side is free");

  a_hold_repeats: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !updated) |-> servo_out == last_servo)
    else $error("held servo value differs from last delivered one");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(servo_out) && $stable(updated))
    else $error("stalled result changed");

endmodule

bind yaw_rate_pid_servo yrp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .servo_out (result.servo_out),
  .updated   (result.updated)
);
